### rtl/eti_pkg.sv
// ----------------------------------------------------------------------------
// eti_pkg: escape-time iteration package
// Widths and fixed-point constants shared by the multiplier and the top
// level, and the saturation helper that the top level uses.
// ----------------------------------------------------------------------------
package eti_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 28;
   localparam int COUNT_BITS = 15;
   localparam int LIMIT_W    = 15;
   localparam int PROD_W     = 2 * DATA_W;
   // floor(square / 2^F) is non-negative and at most 2^(2*DATA_W-2-F)
   localparam int SQ_W       = 2 * DATA_W - 1 - FRAC_BITS;
   // floor(zr*zi / 2^(F-1)) lies within +/- 2^(2*DATA_W-1-F)
   localparam int RI_W       = 2 * DATA_W + 1 - FRAC_BITS;
   localparam int MAG_W      = SQ_W + 1;
   localparam int MAG_OUT_W  = 35;

   localparam int CNT_W_EFF  = (COUNT_BITS < LIMIT_W) ? COUNT_BITS : LIMIT_W;
   localparam logic [LIMIT_W-1:0] CNT_MAX     = LIMIT_W'((1 << CNT_W_EFF) - 1);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

   localparam logic [PROD_W-1:0] FOUR_WIDE    = PROD_W'(4) << FRAC_BITS;
   localparam logic [PROD_W-1:0] MAG_MAX_WIDE = (PROD_W'(1) << MAG_OUT_W) - PROD_W'(1);
   localparam logic [MAG_OUT_W-1:0] MAG_MAX   = {MAG_OUT_W{1'b1}};

   // clamp a wide signed value to the signed data range
   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] x);
      logic [PROD_W-DATA_W:0] top;
      logic signed [DATA_W-1:0] res;
      top = x[PROD_W-1:DATA_W-1];
      if ((&top) || !(|top)) begin
         res = x[DATA_W-1:0];
      end else if (x[PROD_W-1]) begin
         res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

### rtl/eti_mult.sv
// ----------------------------------------------------------------------------
// eti_mult: shared signed multiplier
// One signed data-width product per cycle, with the two floor shifts the
// recurrence needs (square terms and the doubled cross term).
// ----------------------------------------------------------------------------
module eti_mult (
   input  logic signed [eti_pkg::DATA_W-1:0] op_a,
   input  logic signed [eti_pkg::DATA_W-1:0] op_b,
   output logic        [eti_pkg::SQ_W-1:0]   sq_term,
   output logic signed [eti_pkg::RI_W-1:0]   cross_term
);

   logic signed [eti_pkg::PROD_W-1:0] prod;
   logic signed [eti_pkg::PROD_W-1:0] prod_sq;
   logic signed [eti_pkg::PROD_W-1:0] prod_cross;

   assign prod       = eti_pkg::PROD_W'(op_a) * eti_pkg::PROD_W'(op_b);
   // arithmetic shift right is floor division
   assign prod_sq    = prod >>> eti_pkg::FRAC_BITS;
   assign prod_cross = prod >>> (eti_pkg::FRAC_BITS - 1);

   assign sq_term    = prod_sq[eti_pkg::SQ_W-1:0];
   assign cross_term = prod_cross[eti_pkg::RI_W-1:0];

endmodule

### rtl/escape_time_iteration.sv
// ----------------------------------------------------------------------------
// escape_time_iteration: fixed-point escape-time iteration
// Iterates z = z*z + c from z = 0 on one shared multiplier and reports the
// escape step, the final z and its squared magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   A point c is taken when start is high and busy is low. busy stays high
//   while the point iterates; no new word is taken meanwhile.
//   One multiplier is shared by all products. Each step runs through its
//   states in order: zr*zr, zi*zi, zr*zi with the escape compare, then the
//   z update. A zero limit answers in the cycle after start.
//   The result word is on the rsp_ ports for one cycle, marked by rsp_valid,
//   and the receiver cannot stall it. busy drops together with rsp_valid
//   rising, so the next point may be started while the result is shown.
//   csr_wr_en writes iteration_limit; it is to be written only while idle,
//   which the block itself does not enforce.
//   Reset (synchronous) returns the sequencer to idle and the limit to 1000.
// ----------------------------------------------------------------------------
module escape_time_iteration (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [eti_pkg::DATA_W-1:0]    req_c_real,
   input  logic signed [eti_pkg::DATA_W-1:0]    req_c_imag,
   output logic                                 rsp_valid,
   output logic        [eti_pkg::LIMIT_W-1:0]   rsp_iter_count,
   output logic                                 rsp_escaped,
   output logic signed [eti_pkg::DATA_W-1:0]    rsp_z_real,
   output logic signed [eti_pkg::DATA_W-1:0]    rsp_z_imag,
   output logic        [eti_pkg::MAG_OUT_W-1:0] rsp_mag_squared,
   input  logic                                 csr_wr_en,
   input  logic        [eti_pkg::LIMIT_W-1:0]   csr_wr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RR   = 3'd1;
   localparam logic [2:0] ST_II   = 3'd2;
   localparam logic [2:0] ST_RI   = 3'd3;
   localparam logic [2:0] ST_UP   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [eti_pkg::LIMIT_W-1:0] limit_cfg_ff;
   logic [eti_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [eti_pkg::LIMIT_W-1:0] n_ff, n_in;
   logic first_ff, first_in;

   logic signed [eti_pkg::DATA_W-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [eti_pkg::DATA_W-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic        [eti_pkg::SQ_W-1:0]   rr_ff, rr_in, ii_ff, ii_in;
   logic signed [eti_pkg::RI_W-1:0]   ri_ff, ri_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [eti_pkg::LIMIT_W-1:0]       rsp_iter_ff, rsp_iter_in;
   logic                              rsp_esc_ff, rsp_esc_in;
   logic signed [eti_pkg::DATA_W-1:0] rsp_zr_ff, rsp_zr_in, rsp_zi_ff, rsp_zi_in;
   logic [eti_pkg::MAG_OUT_W-1:0]     rsp_mag_ff, rsp_mag_in;

   logic signed [eti_pkg::DATA_W-1:0] mul_a, mul_b;
   logic        [eti_pkg::SQ_W-1:0]   sq_term;
   logic signed [eti_pkg::RI_W-1:0]   cross_term;

   logic [eti_pkg::MAG_W-1:0]          mag_sum;
   logic [eti_pkg::PROD_W-1:0]         mag_wide;
   logic [eti_pkg::MAG_OUT_W-1:0]      mag_sat;
   logic                               mag_over;
   logic signed [eti_pkg::PROD_W-1:0]  re_sum, im_sum;
   logic [eti_pkg::LIMIT_W-1:0]        limit_start;

   // operand select for the shared multiplier
   assign mul_a = (state_ff == ST_II) ? zi_ff : zr_ff;
   assign mul_b = (state_ff == ST_RR) ? zr_ff : zi_ff;

   eti_mult u_mult (
      .op_a       (mul_a),
      .op_b       (mul_b),
      .sq_term    (sq_term),
      .cross_term (cross_term)
   );

   // squared magnitude of the current z from the stored square terms
   assign mag_sum  = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign mag_wide = eti_pkg::PROD_W'(mag_sum);
   assign mag_over = mag_wide > eti_pkg::FOUR_WIDE;
   assign mag_sat  = (mag_wide > eti_pkg::MAG_MAX_WIDE) ? eti_pkg::MAG_MAX
                                                       : eti_pkg::MAG_OUT_W'(mag_sum);

   assign re_sum = eti_pkg::PROD_W'($signed({1'b0, rr_ff}))
                 - eti_pkg::PROD_W'($signed({1'b0, ii_ff}))
                 + eti_pkg::PROD_W'(cr_ff);
   assign im_sum = eti_pkg::PROD_W'(ri_ff) + eti_pkg::PROD_W'(ci_ff);

   assign limit_start = (limit_cfg_ff > eti_pkg::CNT_MAX) ? eti_pkg::CNT_MAX : limit_cfg_ff;

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      n_in         = n_ff;
      first_in     = first_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      ri_in        = ri_ff;
      rsp_valid_in = 1'b0;
      rsp_iter_in  = rsp_iter_ff;
      rsp_esc_in   = rsp_esc_ff;
      rsp_zr_in    = rsp_zr_ff;
      rsp_zi_in    = rsp_zi_ff;
      rsp_mag_in   = rsp_mag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cr_in    = req_c_real;
               ci_in    = req_c_imag;
               zr_in    = '0;
               zi_in    = '0;
               n_in     = '0;
               first_in = 1'b1;
               limit_in = limit_start;
               if (limit_start == '0) begin
                  // no step taken: answer at once with z = 0
                  rsp_valid_in = 1'b1;
                  rsp_iter_in  = '0;
                  rsp_esc_in   = 1'b0;
                  rsp_zr_in    = '0;
                  rsp_zi_in    = '0;
                  rsp_mag_in   = '0;
               end else begin
                  state_in = ST_RR;
               end
            end
         end
         ST_RR: begin
            rr_in    = sq_term;
            state_in = ST_II;
         end
         ST_II: begin
            ii_in    = sq_term;
            state_in = ST_RI;
         end
         ST_RI: begin
            ri_in    = cross_term;
            state_in = ST_UP;
            if (first_ff) begin
               first_in = 1'b0;
            end else begin
               rsp_zr_in  = zr_ff;
               rsp_zi_in  = zi_ff;
               rsp_mag_in = mag_sat;
               if (mag_over) begin
                  rsp_valid_in = 1'b1;
                  rsp_iter_in  = n_ff;
                  rsp_esc_in   = 1'b1;
                  state_in     = ST_IDLE;
               end else if (n_ff == limit_ff - eti_pkg::LIMIT_W'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_iter_in  = limit_ff;
                  rsp_esc_in   = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  n_in = n_ff + eti_pkg::LIMIT_W'(1);
               end
            end
         end
         ST_UP: begin
            zr_in    = eti_pkg::sat_data(re_sum);
            zi_in    = eti_pkg::sat_data(im_sum);
            state_in = ST_RR;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_cfg_ff <= eti_pkg::LIMIT_RESET;
         limit_ff     <= '0;
         n_ff         <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         n_ff         <= n_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_cfg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      rr_ff       <= rr_in;
      ii_ff       <= ii_in;
      ri_ff       <= ri_in;
      rsp_iter_ff <= rsp_iter_in;
      rsp_esc_ff  <= rsp_esc_in;
      rsp_zr_ff   <= rsp_zr_in;
      rsp_zi_ff   <= rsp_zi_in;
      rsp_mag_ff  <= rsp_mag_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_iter_count  = rsp_iter_ff;
   assign rsp_escaped     = rsp_esc_ff;
   assign rsp_z_real      = rsp_zr_ff;
   assign rsp_z_imag      = rsp_zi_ff;
   assign rsp_mag_squared = rsp_mag_ff;

   // a bounded point reports the full limit
   a_bounded_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_escaped |-> rsp_iter_count == limit_ff)
      else $error("bounded result count differs from limit");

   // an escaped point reports a step below the limit
   a_escape_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_escaped |-> rsp_iter_count < limit_ff)
      else $error("escape step not below limit");

   // the step counter never reaches the limit while iterating
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> n_ff < limit_ff)
      else $error("step counter out of range");

   // a result word follows either a finished iteration or a zero-limit start
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(reset) |-> $past(state_ff == ST_RI) || $past(start && !busy))
      else $error("result strobe without a source");

endmodule

### sim/tb_escape_time_iteration.sv
// ----------------------------------------------------------------------------
// tb_escape_time_iteration: self-checking bench for escape_time_iteration
// Sends complex points on the start/busy port and checks every result word
// against a fixed-point escape-time predictor kept in the bench, or a stored
// word from the short directed table that comes first. Random points follow,
// over several iteration limits, with the sender idling in bursts.
// ----------------------------------------------------------------------------
module tb_escape_time_iteration;

   localparam int WATCHDOG_CYCLES = 600000;
   localparam int Q_ONE           = 1 << eti_pkg::FRAC_BITS;
   localparam logic signed [eti_pkg::DATA_W-1:0] MIN_Q = 32'sh8000_0000;
   localparam logic signed [eti_pkg::DATA_W-1:0] MAX_Q = 32'sh7fff_ffff;
   localparam int PROBE_COUNT     = 21;

   typedef struct packed {
      logic        [eti_pkg::LIMIT_W-1:0]   iter_count;
      logic                                 escaped;
      logic signed [eti_pkg::DATA_W-1:0]    z_real;
      logic signed [eti_pkg::DATA_W-1:0]    z_imag;
      logic        [eti_pkg::MAG_OUT_W-1:0] mag_squared;
   } escape_word_type;

   typedef struct packed {
      logic        [eti_pkg::LIMIT_W-1:0] limit;
      logic signed [eti_pkg::DATA_W-1:0]  c_real;
      logic signed [eti_pkg::DATA_W-1:0]  c_imag;
      logic                               known;
      escape_word_type                    want;
   } probe_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic signed [eti_pkg::DATA_W-1:0]    req_c_real;
   logic signed [eti_pkg::DATA_W-1:0]    req_c_imag;
   logic                                 rsp_valid;
   logic        [eti_pkg::LIMIT_W-1:0]   rsp_iter_count;
   logic                                 rsp_escaped;
   logic signed [eti_pkg::DATA_W-1:0]    rsp_z_real;
   logic signed [eti_pkg::DATA_W-1:0]    rsp_z_imag;
   logic        [eti_pkg::MAG_OUT_W-1:0] rsp_mag_squared;
   logic                                 csr_wr_en;
   logic        [eti_pkg::LIMIT_W-1:0]   csr_wr_data;

   escape_word_type               pending_results[$];
   logic [eti_pkg::LIMIT_W-1:0]   active_limit;
   bit                            start_high;
   int                            burst_left;
   int                            fail_count;
   int                            quiet_cycles;

   // the limit column groups rows so that the reset limit is used first
   probe_row_type probe_rows [0:PROBE_COUNT-1] = '{
      '{15'd1000, 0, 0, 1'b1, '{15'd1000, 1'b0, 32'sd0, 32'sd0, 35'd0}},
      '{15'd1000, MIN_Q, MIN_Q, 1'b1, '{15'd0, 1'b1, MIN_Q, MIN_Q, eti_pkg::MAG_MAX}},
      '{15'd1000, MAX_Q, MAX_Q, 1'b0, '0},
      '{15'd1000, MIN_Q, MAX_Q, 1'b0, '0},
      '{15'd1000, MAX_Q, MIN_Q, 1'b0, '0},
      // magnitude exactly four never counts as escaped
      '{15'd1000, -2 * Q_ONE, 0, 1'b1,
        '{15'd1000, 1'b0, 32'sd536870912, 32'sd0, 35'd1073741824}},
      '{15'd1000, 2 * Q_ONE + 1, 0, 1'b0, '0},
      '{15'd1000, Q_ONE / 4, 0, 1'b0, '0},
      '{15'd1000, -Q_ONE, 0, 1'b0, '0},
      '{15'd1000, 0, Q_ONE, 1'b0, '0},
      '{15'd1000, Q_ONE / 2, 0, 1'b0, '0},
      '{15'd1000, -3 * Q_ONE / 4, Q_ONE / 10, 1'b0, '0},
      '{15'd0, Q_ONE / 3, -Q_ONE / 5, 1'b1, '0},
      '{15'd0, MIN_Q, MAX_Q, 1'b1, '0},
      '{15'd1, Q_ONE / 2, Q_ONE / 2, 1'b0, '0},
      '{15'd1, 0, 0, 1'b1, '{15'd1, 1'b0, 32'sd0, 32'sd0, 35'd0}},
      '{15'd10, -3 * Q_ONE / 2, 0, 1'b0, '0},
      '{15'd10, 3 * Q_ONE / 10, Q_ONE / 2, 1'b0, '0},
      '{15'd10, -Q_ONE, -Q_ONE, 1'b0, '0},
      '{15'd32767, 0, 0, 1'b1, '{15'd32767, 1'b0, 32'sd0, 32'sd0, 35'd0}},
      '{15'd32767, 3 * Q_ONE, -3 * Q_ONE, 1'b0, '0}
   };

   escape_time_iteration DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_c_real      (req_c_real),
      .req_c_imag      (req_c_imag),
      .rsp_valid       (rsp_valid),
      .rsp_iter_count  (rsp_iter_count),
      .rsp_escaped     (rsp_escaped),
      .rsp_z_real      (rsp_z_real),
      .rsp_z_imag      (rsp_z_imag),
      .rsp_mag_squared (rsp_mag_squared),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint clamp_data(input longint x);
      if (x > longint'(MAX_Q)) begin
         return longint'(MAX_Q);
      end else if (x < longint'(MIN_Q)) begin
         return longint'(MIN_Q);
      end
      return x;
   endfunction

   // z = z*z + c from z = 0, floor after each product, stop once |z|^2 > 4
   function automatic escape_word_type iterate_point(
         input logic signed [eti_pkg::DATA_W-1:0] cr,
         input logic signed [eti_pkg::DATA_W-1:0] ci,
         input logic [eti_pkg::LIMIT_W-1:0] limit);
      longint          zr;
      longint          zi;
      longint          rr;
      longint          ii;
      longint          ri;
      longint          mag;
      longint          four;
      int              steps;
      int              n;
      bit              esc;
      escape_word_type w;
      zr    = 0;
      zi    = 0;
      mag   = 0;
      n     = 0;
      esc   = 1'b0;
      four  = longint'(4) << eti_pkg::FRAC_BITS;
      steps = (limit > eti_pkg::CNT_MAX) ? int'(eti_pkg::CNT_MAX) : int'(limit);
      while (!esc && n < steps) begin
         rr  = (zr * zr) >>> eti_pkg::FRAC_BITS;
         ii  = (zi * zi) >>> eti_pkg::FRAC_BITS;
         ri  = (zr * zi) >>> (eti_pkg::FRAC_BITS - 1);
         zr  = clamp_data(rr - ii + longint'(cr));
         zi  = clamp_data(ri + longint'(ci));
         mag = ((zr * zr) >>> eti_pkg::FRAC_BITS) + ((zi * zi) >>> eti_pkg::FRAC_BITS);
         if (mag > four) begin
            esc = 1'b1;
         end else begin
            n++;
         end
      end
      w.iter_count  = eti_pkg::LIMIT_W'(n);
      w.escaped     = esc;
      w.z_real      = zr[eti_pkg::DATA_W-1:0];
      w.z_imag      = zi[eti_pkg::DATA_W-1:0];
      w.mag_squared = (mag > longint'(eti_pkg::MAG_MAX)) ? eti_pkg::MAG_MAX
                                                         : mag[eti_pkg::MAG_OUT_W-1:0];
      return w;
   endfunction

   function automatic logic signed [eti_pkg::DATA_W-1:0] corner_value();
      case ($urandom_range(0, 4))
         0: return MIN_Q;
         1: return MAX_Q;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // sender bursts: lower start and sit out a random gap when a burst ends
   task automatic pace();
      burst_left--;
      if (burst_left <= 0) begin
         start      <= 1'b0;
         start_high  = 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
   endtask

   task automatic send_point(input logic signed [eti_pkg::DATA_W-1:0] cr,
                             input logic signed [eti_pkg::DATA_W-1:0] ci,
                             input logic known, input escape_word_type want);
      req_c_real <= cr;
      req_c_imag <= ci;
      start      <= 1'b1;
      start_high  = 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(known ? want : iterate_point(cr, ci, active_limit));
      pace();
   endtask

   // stop sending and wait for every outstanding word
   task automatic settle();
      if (start_high) begin
         start      <= 1'b0;
         start_high  = 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [eti_pkg::LIMIT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_limit = value;
   endtask

   always @(posedge clock) begin
      escape_word_type exp_word;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result word with nothing outstanding");
            end else begin
               exp_word = pending_results.pop_front();
               if (rsp_iter_count !== exp_word.iter_count)
                  report_mismatch($sformatf("iter_count exp %0d got %0d",
                                            exp_word.iter_count, rsp_iter_count));
               if (rsp_escaped !== exp_word.escaped)
                  report_mismatch($sformatf("escaped exp %0b got %0b",
                                            exp_word.escaped, rsp_escaped));
               if (rsp_z_real !== exp_word.z_real)
                  report_mismatch($sformatf("z_real exp %h got %h",
                                            exp_word.z_real, rsp_z_real));
               if (rsp_z_imag !== exp_word.z_imag)
                  report_mismatch($sformatf("z_imag exp %h got %h",
                                            exp_word.z_imag, rsp_z_imag));
               if (rsp_mag_squared !== exp_word.mag_squared)
                  report_mismatch($sformatf("mag_squared exp %h got %h",
                                            exp_word.mag_squared, rsp_mag_squared));
            end
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int                                phase;
      int                                count;
      int                                kind;
      logic [eti_pkg::LIMIT_W-1:0]       limit;
      logic signed [eti_pkg::DATA_W-1:0] cr;
      logic signed [eti_pkg::DATA_W-1:0] ci;
      fail_count   = 0;
      quiet_cycles = 0;
      start_high   = 1'b0;
      active_limit = eti_pkg::LIMIT_RESET;
      burst_left   = $urandom_range(1, 12);
      reset       <= 1'b1;
      start       <= 1'b0;
      req_c_real  <= '0;
      req_c_imag  <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (probe_rows[i]) begin
         if (probe_rows[i].limit != active_limit) begin
            settle();
            write_limit(probe_rows[i].limit);
         end
         send_point(probe_rows[i].c_real, probe_rows[i].c_imag,
                    probe_rows[i].known, probe_rows[i].want);
      end

      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: limit = eti_pkg::LIMIT_W'(10);
            1: limit = eti_pkg::LIMIT_W'($urandom_range(1, 9));
            2: limit = '0;
            3: limit = eti_pkg::LIMIT_W'($urandom_range(100, 300));
            default: limit = eti_pkg::LIMIT_W'($urandom_range(11, 64));
         endcase
         count = (phase == 2) ? 15 : (phase == 3) ? 20 : 67;
         settle();
         write_limit(limit);
         repeat (count) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
               cr = $urandom;
               ci = $urandom;
            end else if (kind < 65) begin
               // box around the whole set
               cr = -9 * Q_ONE / 4 + $urandom_range(0, 3 * Q_ONE);
               ci = -3 * Q_ONE / 2 + $urandom_range(0, 3 * Q_ONE);
            end else if (kind < 85) begin
               // mostly inside the main cardioid, runs to the limit
               cr = -Q_ONE / 2 + $urandom_range(0, 3 * Q_ONE / 4);
               ci = -Q_ONE / 2 + $urandom_range(0, Q_ONE);
            end else if (kind < 95) begin
               // a few ulps around the tip at -2
               cr = -2 * Q_ONE + $urandom_range(0, 64) - 32;
               ci = $urandom_range(0, 64) - 32;
            end else begin
               cr = corner_value();
               ci = corner_value();
            end
            send_point(cr, ci, 1'b0, '0);
         end
      end

      settle();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/eti_pkg.sv
rtl/eti_mult.sv
rtl/escape_time_iteration.sv
sim/tb_escape_time_iteration.sv
